// ===== hdl/rfe_pkg.sv =====
package rfe_pkg;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_RX    = 2'd2;

  // Result kinds on the output channel.
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  // Frame constants.
  localparam logic [7:0]  CMD_FLAG  = 8'h80;
  localparam logic [7:0]  FILL_BYTE = 8'hFF;
  localparam logic [31:0] BAD_WORD  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] reg_address;
    logic [31:0] write_data;
    logic [2:0]  byte_count;
    logic [7:0]  rx_byte;
  } rfe_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic [31:0] read_word;
    logic        checksum_error;
    logic        frame_last;
  } rfe_out_t;

  // Work handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_WORD  = 2'd2
  } rfe_op_t;

  typedef struct packed {
    rfe_op_t     op;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [31:0] data;
    logic [2:0]  n;
    logic        err;
  } rfe_desc_t;

endpackage

// ===== hdl/rfe_front.sv =====
module rfe_front #(
  parameter int MAX_DATA_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rfe_pkg::rfe_in_t   in_data,
  input  logic               q_full,
  output logic               q_push,
  output rfe_pkg::rfe_desc_t q_desc
);
  import rfe_pkg::*;

  logic        pending_r, pending_nxt;
  logic [2:0]  expected_r, expected_nxt;
  logic [2:0]  received_r, received_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [31:0] word_r, word_nxt;

  logic        accept;
  logic [2:0]  n;
  logic [7:0]  lo;
  logic [7:0]  hi;
  logic        bad;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign lo       = in_data.reg_address[7:0];
  assign hi       = {in_data.reg_address[11:8], 4'h0};
  assign bad      = (in_data.rx_byte != ~sum_r);

  // Clamp the data byte count to one through the maximum.
  always_comb begin
    if (in_data.byte_count == 3'd0) begin
      n = 3'd1;
    end else if (in_data.byte_count > 3'(MAX_DATA_BYTES)) begin
      n = 3'(MAX_DATA_BYTES);
    end else begin
      n = in_data.byte_count;
    end
  end

  // Classify the item, update the receive state and build the work item.
  always_comb begin
    pending_nxt  = pending_r;
    expected_nxt = expected_r;
    received_nxt = received_r;
    sum_nxt      = sum_r;
    word_nxt     = word_r;
    q_push       = 1'b0;
    q_desc.op    = OP_WRITE;
    q_desc.lo    = lo;
    q_desc.hi    = hi;
    q_desc.data  = in_data.write_data;
    q_desc.n     = n;
    q_desc.err   = 1'b0;
    if (accept) begin
      case (in_data.req_type)
        REQ_WRITE: begin
          pending_nxt = 1'b0;
          q_desc.hi   = hi + CMD_FLAG;
          q_push      = 1'b1;
        end
        REQ_READ: begin
          pending_nxt  = 1'b1;
          sum_nxt      = lo + hi;
          word_nxt     = '0;
          expected_nxt = n;
          received_nxt = 3'd0;
          q_desc.op    = OP_READ;
          q_push       = 1'b1;
        end
        REQ_RX: begin
          if (pending_r) begin
            if (received_r < expected_r) begin
              word_nxt     = {word_r[23:0], in_data.rx_byte};
              sum_nxt      = sum_r + in_data.rx_byte;
              received_nxt = received_r + 3'd1;
            end else begin
              pending_nxt = 1'b0;
              q_desc.op   = OP_WORD;
              q_desc.data = bad ? BAD_WORD : word_r;
              q_desc.err  = bad;
              q_push      = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= 1'b0;
      expected_r <= 3'd0;
      received_r <= 3'd0;
      sum_r      <= 8'd0;
      word_r     <= 32'd0;
    end else begin
      pending_r  <= pending_nxt;
      expected_r <= expected_nxt;
      received_r <= received_nxt;
      sum_r      <= sum_nxt;
      word_r     <= word_nxt;
    end
  end

endmodule

// ===== hdl/rfe_queue.sv =====
module rfe_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rfe_pkg::rfe_desc_t push_desc,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output rfe_pkg::rfe_desc_t head
);
  import rfe_pkg::*;

  rfe_desc_t  mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== hdl/rfe_back.sv =====
module rfe_back #(
  parameter int MAX_DATA_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  rfe_pkg::rfe_desc_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rfe_pkg::rfe_out_t  out_data
);
  import rfe_pkg::*;

  localparam int SW = $clog2(MAX_DATA_BYTES + 3);

  logic [SW-1:0] step_r, step_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic          out_valid_r, out_valid_nxt;
  rfe_out_t      out_data_r, out_data_nxt;

  logic          emit;
  logic          at_last;
  logic [3:0]    last_step;
  logic [1:0]    byte_idx;
  logic [7:0]    data_byte;
  logic [7:0]    tx;

  assign emit      = !q_empty && (!out_valid_r || !out_stall);
  assign last_step = {1'b0, q_head.n} + 4'd2;
  assign at_last   = (4'(step_r) == last_step);
  assign byte_idx  = q_head.n[1:0] + 2'd1 - step_r[1:0];

  // Data bytes go out most significant first.
  always_comb begin
    case (byte_idx)
      2'd0:    data_byte = q_head.data[7:0];
      2'd1:    data_byte = q_head.data[15:8];
      2'd2:    data_byte = q_head.data[23:16];
      2'd3:    data_byte = q_head.data[31:24];
      default: data_byte = q_head.data[7:0];
    endcase
  end

  // Pick the bus byte for this step of the frame.
  always_comb begin
    if (step_r == SW'(0)) begin
      tx = q_head.lo;
    end else if (step_r == SW'(1)) begin
      tx = q_head.hi;
    end else if (q_head.op == OP_READ) begin
      tx = FILL_BYTE;
    end else if (at_last) begin
      tx = ~sum_r;
    end else begin
      tx = data_byte;
    end
  end

  // Step through the head work item one result per cycle while the output is not stalled.
  always_comb begin
    step_nxt      = step_r;
    sum_nxt       = sum_r;
    q_pop         = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (q_head.op == OP_WORD) begin
        out_data_nxt.result_kind    = KIND_WORD;
        out_data_nxt.tx_byte        = 8'd0;
        out_data_nxt.read_word      = q_head.data;
        out_data_nxt.checksum_error = q_head.err;
        out_data_nxt.frame_last     = 1'b0;
        q_pop                       = 1'b1;
      end else begin
        out_data_nxt.result_kind    = KIND_TX;
        out_data_nxt.tx_byte        = tx;
        out_data_nxt.read_word      = 32'd0;
        out_data_nxt.checksum_error = 1'b0;
        out_data_nxt.frame_last     = at_last;
        sum_nxt                     = (step_r == SW'(0)) ? tx : sum_r + tx;
        if (at_last) begin
          step_nxt = '0;
          q_pop    = 1'b1;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/register_frame_engine_checksum_unit.sv =====
// Register access framer with an inverted additive checksum. The front end
// takes one item per clock while its two-entry work queue has room: a write or
// read command becomes a frame work item, a received byte updates the read
// word and running sum in the front end itself and only the checksum byte
// queues a read-word result. The back end sends one result per clock through
// an output register while the output is not stalled, so a frame with n data
// bytes goes out as n + 3 bytes (at most seven) and a read-word result as a
// single result. Commands are thus limited by the back end byte sequencer,
// and received bytes that produce no result never reach the back end.
module register_frame_engine_checksum_unit #(
  parameter int MAX_DATA_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rfe_pkg::rfe_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rfe_pkg::rfe_out_t out_data
);
  import rfe_pkg::*;

  logic      q_full;
  logic      q_push;
  rfe_desc_t push_desc;
  rfe_desc_t head;
  logic      q_empty;
  logic      q_pop;

  rfe_front #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  rfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  rfe_back #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The front end never writes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("work item pushed into a full queue");

  // The back end never pops an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("work item popped from an empty queue");

  // A read-word result carries no bus byte and never ends a frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_kind == KIND_WORD)
      |-> (!out_data.frame_last && out_data.tx_byte == 8'd0))
    else $error("read-word result carries bus byte fields");

  // A checksum mismatch always reports the all-ones word.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.checksum_error) |-> (out_data.read_word == BAD_WORD))
    else $error("checksum error without all-ones word");

endmodule
